/* src/aedm_pkg.sv */
// Shared types and constants of the adaptive EMA dose monitor.
package aedm_pkg;

  localparam int HPC_W     = 20;   // hot-pixel count field width
  localparam int RPP_W     = 20;   // rad_per_pixel width
  localparam int ALPHA_W   = 16;   // Q0.16 filter weight
  localparam int LEVEL_W   = 32;   // Q4.28 level
  localparam int TS_W      = 48;   // millisecond timestamp
  localparam int DOSE_W    = 64;   // dose sum
  localparam int PERIOD_W  = 16;   // frame period and cooldown width
  localparam int CFG_W     = 32;   // widest configuration register
  localparam int CFG_IDX_W = 3;

  localparam int COUNT_BITS_DEF = 20;

  localparam logic [LEVEL_W-1:0]  LEVEL_FLOOR = 32'd2684;
  localparam logic [28:0]         ONE_Q28     = 29'h1000_0000;

  localparam logic [RPP_W-1:0]    RPP_RST        = 20'd13422;
  localparam logic [ALPHA_W-1:0]  ALPHA_LOW_RST  = 16'd3277;
  localparam logic [ALPHA_W-1:0]  ALPHA_HIGH_RST = 16'd32768;
  localparam logic [LEVEL_W-1:0]  ALERT_RST      = 32'd13421773;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd50;
  localparam logic [PERIOD_W-1:0] COOLDOWN_RST   = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_RPP        = 3'd1,
    CFG_ALPHA_LOW  = 3'd2,
    CFG_ALPHA_HIGH = 3'd3,
    CFG_ALERT      = 3'd4,
    CFG_PERIOD     = 3'd5,
    CFG_COOLDOWN   = 3'd6
  } aedm_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_ALPHA,
    ST_BLEND,
    ST_DOSE,
    ST_FIN
  } aedm_state_e;

  typedef struct packed {
    logic load;
    logic sample_en;
    logic alpha_en;
    logic blend_en;
    logic dose_en;
    logic commit;
  } aedm_cmd_t;

  typedef struct packed {
    logic enable;
  } aedm_sts_t;

endpackage

/* src/aedm_ctrl.sv */
// Sequencing controller of the adaptive EMA dose monitor.
module aedm_ctrl
  import aedm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  aedm_sts_t sts_i,
  output aedm_cmd_t cmd_o
);

  aedm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && sts_i.enable) state_d = ST_SAMPLE;
      ST_SAMPLE: state_d = ST_ALPHA;
      ST_ALPHA:  state_d = ST_BLEND;
      ST_BLEND:  state_d = ST_DOSE;
      ST_DOSE:   state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i && sts_i.enable;
      end
      ST_SAMPLE: cmd_o.sample_en = 1'b1;
      ST_ALPHA:  cmd_o.alpha_en  = 1'b1;
      ST_BLEND:  cmd_o.blend_en  = 1'b1;
      ST_DOSE:   cmd_o.dose_en   = 1'b1;
      ST_FIN:    cmd_o.commit    = out_free;
      default:   in_stall_o      = 1'b1;
    endcase
    out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/aedm_dp.sv */
// Datapath of the adaptive EMA dose monitor: registers, filter and dose arithmetic.
module aedm_dp
  import aedm_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic [HPC_W-1:0]      hot_pixel_count_i,
  input  logic [TS_W-1:0]       timestamp_ms_i,
  input  aedm_cmd_t             cmd_i,
  output aedm_sts_t             sts_o,
  output logic [LEVEL_W-1:0]    filtered_level_o,
  output logic [ALPHA_W-1:0]    alpha_used_o,
  output logic [DOSE_W-1:0]     total_dose_o,
  output logic                  alert_o
);

  localparam int CNT_W  = (COUNT_BITS < HPC_W) ? COUNT_BITS : HPC_W;
  localparam int PROD_W = CNT_W + RPP_W;
  localparam int PEXT_W = HPC_W + RPP_W;
  localparam int BL_W   = LEVEL_W + 18;

  // Configuration registers.
  logic                enable_q;
  logic [RPP_W-1:0]    rpp_q;
  logic [ALPHA_W-1:0]  alpha_low_q, alpha_high_q;
  logic [LEVEL_W-1:0]  alert_level_q;
  logic [PERIOD_W-1:0] period_q, cooldown_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      rpp_q         <= RPP_RST;
      alpha_low_q   <= ALPHA_LOW_RST;
      alpha_high_q  <= ALPHA_HIGH_RST;
      alert_level_q <= ALERT_RST;
      period_q      <= PERIOD_RST;
      cooldown_q    <= COOLDOWN_RST;
    end else if (cfg_we_i) begin
      case (aedm_cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:     enable_q      <= cfg_wdata_i[0];
        CFG_RPP:        rpp_q         <= cfg_wdata_i[RPP_W-1:0];
        CFG_ALPHA_LOW:  alpha_low_q   <= cfg_wdata_i[ALPHA_W-1:0];
        CFG_ALPHA_HIGH: alpha_high_q  <= cfg_wdata_i[ALPHA_W-1:0];
        CFG_ALERT:      alert_level_q <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_PERIOD:     period_q      <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_COOLDOWN:   cooldown_q    <= cfg_wdata_i[PERIOD_W-1:0];
        default:        enable_q      <= enable_q;
      endcase
    end
  end

  assign sts_o.enable = enable_q;

  // Filter and alert state.
  logic [LEVEL_W-1:0] level_reg_q;
  logic               primed_q;
  logic [DOSE_W-1:0]  dose_q, dose_d;
  logic [TS_W-1:0]    last_alert_q;
  logic               alert_d;

  // Per-item working registers.
  logic [CNT_W-1:0]    count_q;
  logic [TS_W-1:0]     ts_q;
  logic [LEVEL_W-1:0]  sample_q, sample_d;
  logic [ALPHA_W-1:0]  alpha_q, alpha_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic [TS_W-1:0]     incr_q;

  // Sample: saturate the scaled count to 32 bits and apply the floor.
  logic [PROD_W-1:0] prod;
  logic [PEXT_W-1:0] prod_ext;
  always_comb begin
    prod     = count_q * rpp_q;
    prod_ext = PEXT_W'(prod);
    if (|prod_ext[PEXT_W-1:LEVEL_W]) begin
      sample_d = '1;
    end else begin
      sample_d = prod_ext[LEVEL_W-1:0];
    end
    if (sample_d < LEVEL_FLOOR) begin
      sample_d = LEVEL_FLOOR;
    end
  end

  // Weight: linear in the clamped distance between sample and level.
  logic [LEVEL_W-1:0] abs_diff;
  logic [28:0]        rate;
  logic [ALPHA_W-1:0] span;
  logic [44:0]        span_rate;
  logic [ALPHA_W:0]   alpha_sum;
  always_comb begin
    abs_diff = (sample_q >= level_reg_q) ? (sample_q - level_reg_q)
                                         : (level_reg_q - sample_q);
    rate      = (abs_diff > LEVEL_W'(ONE_Q28)) ? ONE_Q28 : abs_diff[28:0];
    span      = (alpha_high_q > alpha_low_q) ? (alpha_high_q - alpha_low_q) : '0;
    span_rate = span * rate;
    alpha_sum = {1'b0, alpha_low_q} + {1'b0, span_rate[43:28]};
    alpha_d   = primed_q ? alpha_sum[ALPHA_W-1:0] : alpha_low_q;
  end

  // Blend: level + (sample - level) * alpha, rounded half up.
  logic signed [LEVEL_W:0]   delta;
  logic signed [BL_W-1:0]    blend_prod;
  logic signed [BL_W-1:0]    blend_sum;
  always_comb begin
    delta      = $signed({1'b0, sample_q}) - $signed({1'b0, level_reg_q});
    blend_prod = BL_W'(delta * $signed({1'b0, alpha_q}));
    blend_sum  = $signed({2'b00, level_reg_q, 16'h0000}) + blend_prod
                 + $signed(BL_W'(32768));
    level_d    = primed_q ? blend_sum[LEVEL_W+15:16] : sample_q;
  end

  // Dose sum saturates; the alert needs the level above threshold and the cooldown gone.
  logic [DOSE_W:0] dose_sum;
  logic [TS_W:0]   ts_gap;
  always_comb begin
    dose_sum = {1'b0, dose_q} + (DOSE_W + 1)'(incr_q);
    dose_d   = dose_sum[DOSE_W] ? '1 : dose_sum[DOSE_W-1:0];
    ts_gap   = {1'b0, ts_q} - {1'b0, last_alert_q};
    alert_d  = (level_q > alert_level_q) && !ts_gap[TS_W]
               && (ts_gap[TS_W-1:0] >= TS_W'(cooldown_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      count_q <= hot_pixel_count_i[CNT_W-1:0];
      ts_q    <= timestamp_ms_i;
    end
    if (cmd_i.sample_en) sample_q <= sample_d;
    if (cmd_i.alpha_en)  alpha_q  <= alpha_d;
    if (cmd_i.blend_en)  level_q  <= level_d;
    if (cmd_i.dose_en)   incr_q   <= level_q * period_q;
    if (cmd_i.commit) begin
      filtered_level_o <= level_q;
      alpha_used_o     <= alpha_q;
      total_dose_o     <= dose_d;
      alert_o          <= alert_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_reg_q  <= '0;
      primed_q     <= 1'b0;
      dose_q       <= '0;
      last_alert_q <= '0;
    end else if (cmd_i.commit) begin
      level_reg_q <= level_q;
      primed_q    <= 1'b1;
      dose_q      <= dose_d;
      if (alert_d) begin
        last_alert_q <= ts_q;
      end
    end
  end

endmodule

/* src/adaptive_ema_dose_monitor.sv */
// Top level of the adaptive EMA dose monitor: controller plus datapath.
// An accepted beat passes sample, weight, blend, dose and final states before out_valid_o rises.
// A new input beat is taken only in the idle state, after the five working states of the last.
// A stalled result holds its beat; the next item is still taken and waits in its final state,
// and the input stalls from then on until the result register frees.
// Reset (rst_ni low, asynchronous) restores register defaults, clears the filter and dose.
module adaptive_ema_dose_monitor
  import aedm_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes: the user must issue them only while the monitor is idle; the block does not enforce it.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  // Input channel: one beat per camera frame.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [HPC_W-1:0]      hot_pixel_count_i,
  input  logic [TS_W-1:0]       timestamp_ms_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEVEL_W-1:0]    filtered_level_o,
  output logic [ALPHA_W-1:0]    alpha_used_o,
  output logic [DOSE_W-1:0]     total_dose_o,
  output logic                  alert_o
);

  // The controller walks each accepted beat through sample, weight, blend,
  // dose product and final commit. When the monitor is disabled an input beat
  // is still taken, but it is dropped without producing a result.
  aedm_cmd_t cmd;
  aedm_sts_t sts;

  aedm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the filter state and the result
  // register. Filter state changes only in the commit cycle, so a dropped
  // or waiting beat leaves it untouched.
  aedm_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .hot_pixel_count_i (hot_pixel_count_i),
    .timestamp_ms_i    (timestamp_ms_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .filtered_level_o  (filtered_level_o),
    .alpha_used_o      (alpha_used_o),
    .total_dose_o      (total_dose_o),
    .alert_o           (alert_o)
  );

endmodule

/* src/aedm_chk.sv */
// Port-level checker of the adaptive EMA dose monitor and its bind.
module aedm_chk
  import aedm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [DOSE_W-1:0]  total_dose_o
);

  logic [DOSE_W-1:0] last_dose_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dose_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      last_dose_q <= total_dose_o;
    end
  end

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A new result only appears after the block was busy working on an item.
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a busy phase");

  // No result can follow an input beat in the very next cycle.
  a_no_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result followed its input too early");

  // The accumulated dose never shrinks from one result beat to the next.
  a_dose_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> total_dose_o >= last_dose_q)
    else $error("total dose decreased");

endmodule

bind adaptive_ema_dose_monitor aedm_chk u_aedm_chk (.*);
